/* hdl/tgc_pkg.sv */
// Shared widths, codes, types and the coordinate clamp of the touch gesture classifier.
package tgc_pkg;

  localparam int COORD_W    = 12;
  localparam int SIZE_W     = 13;
  localparam int DELTA_W    = 13;
  localparam int TIME_W     = 32;
  localparam int MS_W       = 16;
  localparam int RAW_W      = 16;
  localparam int CNT_W      = 3;
  localparam int GEST_W     = 2;
  localparam int MOVE_W     = 12;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // largest usable screen dimension
  localparam logic [SIZE_W-1:0] COORD_LIMIT = SIZE_W'(4096);

  // gesture codes
  localparam logic [GEST_W-1:0] GEST_TAP    = GEST_W'(0);
  localparam logic [GEST_W-1:0] GEST_LONG   = GEST_W'(1);
  localparam logic [GEST_W-1:0] GEST_HSWIPE = GEST_W'(2);
  localparam logic [GEST_W-1:0] GEST_VSWIPE = GEST_W'(3);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE        = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DEB   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN_MS   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MAX_MOVE = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_HSWIPE_MIN_DX = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_VSWIPE_MIN_DY = CFG_IDX_W'(7);

  typedef struct packed {
    logic                enable;
    logic [SIZE_W-1:0]   screen_width;
    logic [SIZE_W-1:0]   screen_height;
    logic [MS_W-1:0]     release_debounce_ms;
    logic [MS_W-1:0]     long_press_min_ms;
    logic [MOVE_W-1:0]   long_press_max_move;
    logic [MOVE_W-1:0]   hswipe_min_dx;
    logic [MOVE_W-1:0]   vswipe_min_dy;
  } cfg_t;

  // one registered poll, coordinates already clamped
  typedef struct packed {
    logic [TIME_W-1:0]  now_ms;
    logic               contact;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
  } poll_t;

  // clamp a signed raw coordinate to [0, size-1]; size 0 acts as 1, above 4096 as 4096
  function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [RAW_W-1:0] raw,
                                                     input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0]  s;
    logic [COORD_W-1:0] hi;
    s = size;
    if (s == '0) s = SIZE_W'(1);
    if (s > COORD_LIMIT) s = COORD_LIMIT;
    hi = COORD_W'(s - SIZE_W'(1));
    if (raw[RAW_W-1]) begin
      clamp_coord = '0;
    end else if (raw[RAW_W-2:0] > {{(RAW_W-1-COORD_W){1'b0}}, hi}) begin
      clamp_coord = hi;
    end else begin
      clamp_coord = raw[COORD_W-1:0];
    end
  endfunction

endpackage

/* hdl/tgc_if.sv */
// Channel interfaces: poll input, gesture event output and configuration write.
interface tgc_in_if import tgc_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [TIME_W-1:0]        now_ms;
  logic [CNT_W-1:0]         point_count;
  logic signed [RAW_W-1:0]  raw_x;
  logic signed [RAW_W-1:0]  raw_y;

  modport source (output valid, now_ms, point_count, raw_x, raw_y, input ready);
  modport sink   (input valid, now_ms, point_count, raw_x, raw_y, output ready);
endinterface

interface tgc_out_if import tgc_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [GEST_W-1:0]         gesture;
  logic [COORD_W-1:0]        start_x;
  logic [COORD_W-1:0]        start_y;
  logic [COORD_W-1:0]        end_x;
  logic [COORD_W-1:0]        end_y;
  logic signed [DELTA_W-1:0] delta_x;
  logic signed [DELTA_W-1:0] delta_y;
  logic [TIME_W-1:0]         duration_ms;

  modport source (output valid, gesture, start_x, start_y, end_x, end_y, delta_x, delta_y,
                  duration_ms, input ready);
  modport sink   (input valid, gesture, start_x, start_y, end_x, end_y, delta_x, delta_y,
                  duration_ms, output ready);
endinterface

interface tgc_cfg_if import tgc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/tgc_cfg_regs.sv */
// Configuration register file of the touch gesture classifier.
module tgc_cfg_regs import tgc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tgc_cfg_if.sink   cfg_ch,
  output cfg_t      cfg
);

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  // decode one write beat; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ENABLE:        cfg_nxt.enable              = cfg_ch.data[0];
        REG_SCREEN_WIDTH:  cfg_nxt.screen_width        = cfg_ch.data[SIZE_W-1:0];
        REG_SCREEN_HEIGHT: cfg_nxt.screen_height       = cfg_ch.data[SIZE_W-1:0];
        REG_RELEASE_DEB:   cfg_nxt.release_debounce_ms = cfg_ch.data[MS_W-1:0];
        REG_LONG_MIN_MS:   cfg_nxt.long_press_min_ms   = cfg_ch.data[MS_W-1:0];
        REG_LONG_MAX_MOVE: cfg_nxt.long_press_max_move = cfg_ch.data[MOVE_W-1:0];
        REG_HSWIPE_MIN_DX: cfg_nxt.hswipe_min_dx       = cfg_ch.data[MOVE_W-1:0];
        REG_VSWIPE_MIN_DY: cfg_nxt.vswipe_min_dy       = cfg_ch.data[MOVE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable              <= 1'b0;
      cfg_r.screen_width        <= SIZE_W'(540);
      cfg_r.screen_height       <= SIZE_W'(960);
      cfg_r.release_debounce_ms <= MS_W'(80);
      cfg_r.long_press_min_ms   <= MS_W'(700);
      cfg_r.long_press_max_move <= MOVE_W'(40);
      cfg_r.hswipe_min_dx       <= MOVE_W'(90);
      cfg_r.vswipe_min_dy       <= MOVE_W'(120);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* hdl/tgc_front.sv */
// Input register stage: takes a poll beat, clamps its point and holds it for the core.
module tgc_front import tgc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  tgc_in_if.sink   in_ch,
  input  cfg_t     cfg,
  input  logic     advance,
  output logic     poll_valid,
  output poll_t    poll
);

  logic  vld_r, vld_nxt;
  poll_t poll_r;
  logic  take;

  // free when empty or when the core consumes the held poll this cycle
  assign in_ch.ready = !vld_r || advance;
  assign take        = in_ch.valid && in_ch.ready;
  assign poll_valid  = vld_r;
  assign poll        = poll_r;

  always_comb begin
    vld_nxt = vld_r;
    if (advance) vld_nxt = 1'b0;
    if (take)    vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload, clamped on the way in
  always_ff @(posedge clk) begin
    if (take) begin
      poll_r.now_ms  <= in_ch.now_ms;
      poll_r.contact <= (in_ch.point_count != '0);
      poll_r.px      <= clamp_coord(in_ch.raw_x, cfg.screen_width);
      poll_r.py      <= clamp_coord(in_ch.raw_y, cfg.screen_height);
    end
  end

endmodule

/* hdl/tgc_core.sv */
// Press tracking state, release detection, gesture classification and event register.
module tgc_core import tgc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      poll_valid,
  input  poll_t     poll,
  output logic      advance,
  tgc_out_if.source out_ch
);

  // press state
  logic               pressed_r;
  logic [TIME_W-1:0]  start_time_r;
  logic [TIME_W-1:0]  last_time_r;
  logic [COORD_W-1:0] down_x_r, down_y_r, latest_x_r, latest_y_r;

  // event register
  logic                      out_valid_r, out_valid_nxt;
  logic [GEST_W-1:0]         gesture_r;
  logic [COORD_W-1:0]        start_x_r, start_y_r, end_x_r, end_y_r;
  logic signed [DELTA_W-1:0] delta_x_r, delta_y_r;
  logic [TIME_W-1:0]         duration_r;

  logic [TIME_W-1:0]         quiet_ms, dur;
  logic [DELTA_W-1:0]        dx, dy;
  logic [MOVE_W-1:0]         adx, ady;
  logic                      fire, active;
  logic [GEST_W-1:0]         kind;

  // release check
  assign active   = poll_valid && cfg.enable;
  assign quiet_ms = poll.now_ms - last_time_r;
  assign fire     = active && !poll.contact && pressed_r &&
                    (quiet_ms >= {{(TIME_W-MS_W){1'b0}}, cfg.release_debounce_ms});

  // a poll moves on unless it has an event and the event slot stays full
  assign advance = poll_valid && (!fire || !out_valid_r || out_ch.ready);

  // motion and duration of the closing press
  assign dur = poll.now_ms - start_time_r;
  assign dx  = {1'b0, latest_x_r} - {1'b0, down_x_r};
  assign dy  = {1'b0, latest_y_r} - {1'b0, down_y_r};
  assign adx = dx[DELTA_W-1] ? MOVE_W'(-dx) : dx[MOVE_W-1:0];
  assign ady = dy[DELTA_W-1] ? MOVE_W'(-dy) : dy[MOVE_W-1:0];

  // classification, first match wins
  always_comb begin
    if ((dur >= {{(TIME_W-MS_W){1'b0}}, cfg.long_press_min_ms}) &&
        (adx < cfg.long_press_max_move) && (ady < cfg.long_press_max_move)) begin
      kind = GEST_LONG;
    end else if ((adx >= cfg.hswipe_min_dx) && ({1'b0, adx} > {ady, 1'b0})) begin
      kind = GEST_HSWIPE;
    end else if ((ady >= cfg.vswipe_min_dy) && ({1'b0, ady} > {adx, 1'b0})) begin
      kind = GEST_VSWIPE;
    end else begin
      kind = GEST_TAP;
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r    <= 1'b0;
      start_time_r <= '0;
      last_time_r  <= '0;
      down_x_r     <= '0;
      down_y_r     <= '0;
      latest_x_r   <= '0;
      latest_y_r   <= '0;
    end else if (advance && active) begin
      if (poll.contact) begin
        latest_x_r  <= poll.px;
        latest_y_r  <= poll.py;
        last_time_r <= poll.now_ms;
        if (!pressed_r) begin
          pressed_r    <= 1'b1;
          start_time_r <= poll.now_ms;
          down_x_r     <= poll.px;
          down_y_r     <= poll.py;
        end
      end else if (fire) begin
        pressed_r <= 1'b0;
      end
    end
  end

  // event slot handshake
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (advance && fire) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire) begin
      gesture_r  <= kind;
      start_x_r  <= down_x_r;
      start_y_r  <= down_y_r;
      end_x_r    <= latest_x_r;
      end_y_r    <= latest_y_r;
      delta_x_r  <= dx;
      delta_y_r  <= dy;
      duration_r <= dur;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.gesture     = gesture_r;
  assign out_ch.start_x     = start_x_r;
  assign out_ch.start_y     = start_y_r;
  assign out_ch.end_x       = end_x_r;
  assign out_ch.end_y       = end_y_r;
  assign out_ch.delta_x     = delta_x_r;
  assign out_ch.delta_y     = delta_y_r;
  assign out_ch.duration_ms = duration_r;

endmodule

/* hdl/touch_gesture_classifier_unit.sv */
// Top level of the touch gesture classifier: tap, long press and swipe recognizer.
//
// Channels: in_ch takes one touch-controller poll per beat (time stamp, point count,
// raw first point). out_ch delivers one gesture event per beat: kind, start and end
// point, signed deltas and press duration. cfg_ch writes one register per beat and is
// always ready; write it only while no poll is in flight.
// Throughput: one poll per cycle unless a poll that closes a press waits on out_ch.
// Each poll passes an input register (clamp) and one pass of compare logic into the
// event register, which drives out_ch. Polls without an event never wait on out_ch.
// Stall: while an event waits in the output register, polls that cause no event keep
// flowing; a poll that closes a press waits in the input register until the event
// ahead is taken, which then back-pressures in_ch.
// Reset (rst_n low, synchronous): no press in progress, empty registers, all
// configuration back to its defaults with the block disabled.
module touch_gesture_classifier_unit import tgc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tgc_in_if.sink    in_ch,
  tgc_out_if.source out_ch,
  tgc_cfg_if.sink   cfg_ch
);

  cfg_t  cfg;
  poll_t poll;
  logic  poll_valid;
  logic  advance;

  tgc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  tgc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg),
    .advance    (advance),
    .poll_valid (poll_valid),
    .poll       (poll)
  );

  tgc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .poll_valid (poll_valid),
    .poll       (poll),
    .advance    (advance),
    .out_ch     (out_ch)
  );

endmodule
